@@ rtl/core/tun_pkg.sv @@
// Package for the triangle unit normal block: field widths, item types and the
// records handed between pipeline cells. No dependencies.
package tun_pkg;

    localparam int CW        = 16;                 // input coordinate width
    localparam int OUT_FRAC  = 14;                 // fraction bits of the normal
    localparam int OW        = OUT_FRAC + 2;       // output component width
    localparam int DW        = CW + 1;             // edge vector width
    localparam int PW        = 2 * DW;             // product and magnitude width
    localparam int LW        = $clog2(PW + 1);     // bit length width
    localparam int ALIGN     = 30;                 // aligned magnitude width
    localparam int SW        = 2 * ALIGN + 2;      // sum of squares width
    localparam int SQ_STEPS  = SW / 2;             // root bits, one per cell
    localparam int RW        = SQ_STEPS;           // root width
    localparam int SRW       = RW + 2;             // root remainder width
    localparam int QW        = OUT_FRAC + 1;       // quotient width, one bit per cell
    localparam int NW        = ALIGN + OUT_FRAC + 2; // dividend width
    localparam int DRW       = RW + 1;             // divisor and remainder width

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0] nx;
        logic signed [OW-1:0] ny;
        logic signed [OW-1:0] nz;
        logic                 degenerate;
    } t_out;

    typedef struct packed {
        logic [2:0][ALIGN-1:0] m;
        logic [2:0]            neg;
        logic                  degen;
    } t_carry;

    typedef struct packed {
        t_carry         c;
        logic [SW-1:0]  s;
        logic [SRW-1:0] rem;
        logic [RW-1:0]  root;
    } t_sq;

    typedef struct packed {
        logic [2:0]            neg;
        logic                  degen;
        logic [2:0][QW-1:0]    n;
        logic [2:0][DRW-1:0]   rem;
        logic [2:0][QW-1:0]    q;
        logic [DRW-1:0]        d;
    } t_dv;

endpackage

@@ rtl/core/tun_front.sv @@
// Front stages of the triangle unit normal: edge vectors, cross product,
// alignment and sum of squares. Depends on tun_pkg.
module tun_front import tun_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_rdy,
    output logic o_valid,
    output t_sq  o_data,
    input  logic i_rdy
);

    localparam int NST = 7;

    logic [NST-1:0] r_v;
    logic [NST-1:0] rdy;
    logic [NST-1:0] v_in;

    logic signed [DW-1:0] r_u [3];
    logic signed [DW-1:0] r_w [3];
    logic signed [DW-1:0] n_u [3];
    logic signed [DW-1:0] n_w [3];
    logic signed [PW-1:0] r_pr [6];
    logic signed [PW-1:0] n_pr [6];
    logic [PW-1:0]        r_mag3 [3];
    logic [PW-1:0]        n_mag3 [3];
    logic [2:0]           r_neg3;
    logic [2:0]           n_neg3;
    logic [PW-1:0]        r_mag4 [3];
    logic [2:0]           r_neg4;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        n_len;
    t_carry               r_c5;
    t_carry               n_c5;
    t_carry               r_c6;
    logic [2*ALIGN-1:0]   r_sq [3];
    t_sq                  r_o;
    t_sq                  n_o;

    always_comb begin
        rdy[NST-1] = !r_v[NST-1] || i_rdy;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        v_in = {r_v[NST-2:0], i_valid};
    end

    assign o_rdy   = rdy[0];
    assign o_valid = r_v[NST-1];
    assign o_data  = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= v_in[k];
                end
            end
        end
    end

    always_comb begin
        n_u[0] = $signed({i_item.bx[CW-1], i_item.bx}) - $signed({i_item.ax[CW-1], i_item.ax});
        n_u[1] = $signed({i_item.by[CW-1], i_item.by}) - $signed({i_item.ay[CW-1], i_item.ay});
        n_u[2] = $signed({i_item.bz[CW-1], i_item.bz}) - $signed({i_item.az[CW-1], i_item.az});
        n_w[0] = $signed({i_item.cx[CW-1], i_item.cx}) - $signed({i_item.ax[CW-1], i_item.ax});
        n_w[1] = $signed({i_item.cy[CW-1], i_item.cy}) - $signed({i_item.ay[CW-1], i_item.ay});
        n_w[2] = $signed({i_item.cz[CW-1], i_item.cz}) - $signed({i_item.az[CW-1], i_item.az});
    end

    always_comb begin
        n_pr[0] = r_u[1] * r_w[2];
        n_pr[1] = r_u[2] * r_w[1];
        n_pr[2] = r_u[2] * r_w[0];
        n_pr[3] = r_u[0] * r_w[2];
        n_pr[4] = r_u[0] * r_w[1];
        n_pr[5] = r_u[1] * r_w[0];
    end

    always_comb begin
        logic [PW:0] p;
        logic [PW:0] a;
        for (int i = 0; i < 3; i++) begin
            p = {r_pr[2*i][PW-1], r_pr[2*i]} - {r_pr[2*i+1][PW-1], r_pr[2*i+1]};
            n_neg3[i] = p[PW];
            a = p[PW] ? (~p + 1'b1) : p;
            n_mag3[i] = a[PW-1:0];
        end
    end

    always_comb begin
        logic [PW-1:0] orv;
        orv   = r_mag3[0] | r_mag3[1] | r_mag3[2];
        n_len = '0;
        for (int b = 0; b < PW; b++) begin
            if (orv[b]) begin
                n_len = LW'(b + 1);
            end
        end
    end

    always_comb begin
        logic [PW+ALIGN-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            sh = {r_mag4[i], {ALIGN{1'b0}}} >> r_len;
            n_c5.m[i] = sh[ALIGN-1:0];
        end
        n_c5.neg   = r_neg4;
        n_c5.degen = (r_len == '0);
    end

    always_comb begin
        n_o.c    = r_c6;
        n_o.s    = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        n_o.rem  = '0;
        n_o.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_u <= n_u;
            r_w <= n_w;
        end
        if (rdy[1]) begin
            r_pr <= n_pr;
        end
        if (rdy[2]) begin
            r_mag3 <= n_mag3;
            r_neg3 <= n_neg3;
        end
        if (rdy[3]) begin
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            r_len  <= n_len;
        end
        if (rdy[4]) begin
            r_c5 <= n_c5;
        end
        if (rdy[5]) begin
            r_c6 <= r_c5;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_c5.m[i] * r_c5.m[i];
            end
        end
        if (rdy[6]) begin
            r_o <= n_o;
        end
    end

endmodule

@@ rtl/core/tun_sqrt_cell.sv @@
// One cell of the square root chain: settles one root bit from two bits of
// the sum of squares. Depends on tun_pkg.
module tun_sqrt_cell import tun_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sq  i_data,
    output logic o_rdy,
    output logic o_valid,
    output t_sq  o_data,
    input  logic i_rdy
);

    logic r_v;
    t_sq  r_d;
    t_sq  n_d;

    assign o_rdy   = !r_v || i_rdy;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        logic [SRW+1:0] remsh;
        logic [SRW+1:0] trial;
        logic           ge;
        logic [SRW+1:0] diff;
        remsh = {i_data.rem, i_data.s[SW-1:SW-2]};
        trial = (SRW+2)'({i_data.root, 2'b01});
        ge    = (remsh >= trial);
        diff  = remsh - trial;
        n_d      = i_data;
        n_d.s    = {i_data.s[SW-3:0], 2'b00};
        n_d.rem  = ge ? diff[SRW-1:0] : remsh[SRW-1:0];
        n_d.root = {i_data.root[RW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_d <= n_d;
        end
    end

endmodule

@@ rtl/core/tun_div_cell.sv @@
// One cell of the division chain: settles one quotient bit for each of the
// three components. Depends on tun_pkg.
module tun_div_cell import tun_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_dv  i_data,
    output logic o_rdy,
    output logic o_valid,
    output t_dv  o_data,
    input  logic i_rdy
);

    logic r_v;
    t_dv  r_d;
    t_dv  n_d;

    assign o_rdy   = !r_v || i_rdy;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        logic [DRW:0] r2;
        logic [DRW:0] diff;
        logic         ge;
        n_d = i_data;
        for (int i = 0; i < 3; i++) begin
            r2   = {i_data.rem[i], i_data.n[i][QW-1]};
            ge   = (r2 >= {1'b0, i_data.d});
            diff = r2 - {1'b0, i_data.d};
            n_d.rem[i] = ge ? diff[DRW-1:0] : r2[DRW-1:0];
            n_d.n[i]   = {i_data.n[i][QW-2:0], 1'b0};
            n_d.q[i]   = {i_data.q[i][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_d <= n_d;
        end
    end

endmodule

@@ rtl/core/triangle_unit_normal.sv @@
// Top level of the triangle unit normal block: front stages, square root and
// division cell chains, output register. Depends on tun_pkg and its submodules.
//
// Usage: each input item carries the three corners of a triangle (signed Q8.8).
// Each produces exactly one output item: the unit face normal in signed Q1.14
// and a degenerate flag, set with a zero normal when the corners are collinear.
// Both channels use valid and stall; an item moves on an edge where valid is
// high and stall is low.
// From acceptance to the output, an item passes through seven front stages,
// one square root cell per root bit (31), one set-up stage, one division cell
// per quotient bit (15) and the output register.
// Throughput is one item per cycle while the receiver does not stall; the cell chains are fully pipelined.
// Every stage holds its item while the next is full, so bubbles close up and
// an item is still taken while a finished result waits at the output.
// When the receiver stalls, items back up stage by stage and o_stall rises
// only once the whole pipeline is full.
// Reset clears every stage's valid bit; nothing else is kept between items.
module triangle_unit_normal import tun_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_item
);

    localparam logic [QW-1:0] ONE = QW'(1) << OUT_FRAC;

    logic fr_rdy;
    logic sq_v [SQ_STEPS+1];
    logic sq_r [SQ_STEPS+1];
    t_sq  sq_d [SQ_STEPS+1];
    logic dv_v [QW+1];
    logic dv_r [QW+1];
    t_dv  dv_d [QW+1];

    logic r_pv;
    t_dv  r_p;
    t_dv  n_p;
    logic p_rdy;
    logic r_ov;
    t_out r_o;
    t_out n_o;
    logic o_rdy;

    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_rdy   (fr_rdy),
        .o_valid (sq_v[0]),
        .o_data  (sq_d[0]),
        .i_rdy   (sq_r[0])
    );

    assign o_stall = !fr_rdy;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        tun_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .i_data  (sq_d[k]),
            .o_rdy   (sq_r[k]),
            .o_valid (sq_v[k+1]),
            .o_data  (sq_d[k+1]),
            .i_rdy   (sq_r[k+1])
        );
    end

    assign p_rdy          = !r_pv || dv_r[0];
    assign sq_r[SQ_STEPS] = p_rdy;

    always_comb begin
        logic [NW-1:0] num;
        logic [RW-1:0] len;
        len = sq_d[SQ_STEPS].root;
        n_p.neg   = sq_d[SQ_STEPS].c.neg;
        n_p.degen = sq_d[SQ_STEPS].c.degen;
        n_p.d     = {len, 1'b0};
        n_p.q     = '0;
        for (int i = 0; i < 3; i++) begin
            num = NW'({sq_d[SQ_STEPS].c.m[i], {QW{1'b0}}}) + NW'(len);
            n_p.n[i]   = num[QW-1:0];
            n_p.rem[i] = DRW'(num[NW-1:QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (p_rdy) begin
            r_pv <= sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_rdy) begin
            r_p <= n_p;
        end
    end

    assign dv_v[0] = r_pv;
    assign dv_d[0] = r_p;

    for (genvar k = 0; k < QW; k++) begin : g_div
        tun_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .i_data  (dv_d[k]),
            .o_rdy   (dv_r[k]),
            .o_valid (dv_v[k+1]),
            .o_data  (dv_d[k+1]),
            .i_rdy   (dv_r[k+1])
        );
    end

    assign o_rdy    = !r_ov || !i_stall;
    assign dv_r[QW] = o_rdy;

    always_comb begin
        logic [QW-1:0] qc;
        logic [OW-1:0] mag;
        logic [OW-1:0] val [3];
        for (int i = 0; i < 3; i++) begin
            qc  = (dv_d[QW].q[i] > ONE) ? ONE : dv_d[QW].q[i];
            mag = OW'(qc);
            if (dv_d[QW].degen) begin
                val[i] = '0;
            end else if (dv_d[QW].neg[i]) begin
                val[i] = ~mag + 1'b1;
            end else begin
                val[i] = mag;
            end
        end
        n_o.nx         = val[0];
        n_o.ny         = val[1];
        n_o.nz         = val[2];
        n_o.degenerate = dv_d[QW].degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_rdy) begin
            r_ov <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_o <= n_o;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_o;

endmodule

@@ verif/testbench.sv @@
// Testbench for triangle_unit_normal: random and directed triangles checked
// against a behavioural normal calculator. Depends on tun_pkg and the block.
module testbench;
    import tun_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_item;
    logic o_valid;
    logic i_stall;
    t_out o_item;

    triangle_unit_normal uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    t_in  pending_tris[$];
    t_out expected_normals[$];
    int   errors = 0;
    int   accepted = 0;
    int   received = 0;
    int   degenerate_seen = 0;
    int   idle_cycles = 0;
    bit   hold_sender = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s = s - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_out unit_normal_of(t_in t);
        logic signed [16:0] ux, uy, uz, vx, vy, vz;
        logic signed [63:0] p [3];
        logic [63:0] mag [3];
        logic [63:0] m [3];
        logic [63:0] s, len, q;
        logic [63:0] one;
        logic [OW-1:0] comp [3];
        int maxlen, k, i, b;
        t_out r;
        one = 64'd1 << OUT_FRAC;
        ux = t.bx - t.ax; uy = t.by - t.ay; uz = t.bz - t.az;
        vx = t.cx - t.ax; vy = t.cy - t.ay; vz = t.cz - t.az;
        p[0] = 64'(uy) * 64'(vz) - 64'(uz) * 64'(vy);
        p[1] = 64'(uz) * 64'(vx) - 64'(ux) * 64'(vz);
        p[2] = 64'(ux) * 64'(vy) - 64'(uy) * 64'(vx);
        maxlen = 0;
        for (i = 0; i < 3; i++) begin
            mag[i] = p[i] < 0 ? -p[i] : p[i];
            for (b = 0; b < 64; b++) if (mag[i][b] && b + 1 > maxlen) maxlen = b + 1;
        end
        r = '0;
        if (maxlen == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        k = maxlen - ALIGN;
        for (i = 0; i < 3; i++) m[i] = k > 0 ? mag[i] >> k : mag[i] << (-k);
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root_floor(s);
        for (i = 0; i < 3; i++) begin
            q = ((m[i] << OUT_FRAC) * 2 + len) / (2 * len);
            if (q > one) q = one;
            comp[i] = p[i] < 0 ? OW'(-q) : OW'(q);
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        return r;
    endfunction

    function automatic logic [15:0] coord_pick(int mode);
        case (mode)
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in random_tri();
        t_in t;
        int mode, sel;
        mode = $urandom_range(0, 9);
        t.ax = mode < 2 ? coord_pick(mode) : coord_pick($urandom_range(0, 9));
        t.ay = coord_pick($urandom_range(0, 9));
        t.az = coord_pick($urandom_range(0, 9));
        t.bx = coord_pick($urandom_range(0, 9));
        t.by = coord_pick($urandom_range(0, 9));
        t.bz = coord_pick($urandom_range(0, 9));
        t.cx = coord_pick($urandom_range(0, 9));
        t.cy = coord_pick($urandom_range(0, 9));
        t.cz = coord_pick($urandom_range(0, 9));
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            t.bx = t.ax; t.by = t.ay; t.bz = t.az;
        end else if (sel == 1) begin
            t.cx = t.bx + (t.bx - t.ax); t.cy = t.by + (t.by - t.ay);
            t.cz = t.bz + (t.bz - t.az);
        end else if (sel < 5) begin
            t.bx = t.ax + 16'($urandom_range(0, 3)); t.by = t.ay + 16'($urandom_range(0, 3));
            t.bz = t.az; t.cx = t.ax; t.cy = t.ay + 16'($urandom_range(0, 3));
            t.cz = t.az + 16'($urandom_range(0, 3));
        end
        return t;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", received, what, got,
                 want);
        errors++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (pending_tris.size() > 0 && !hold_sender) begin
                i_item  <= pending_tris.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            expected_normals.push_back(unit_normal_of(i_item));
            accepted++;
        end
    end

    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            recv_gap = gap_len();
            i_stall <= recv_gap > 0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = expected_normals.pop_front();
                if (o_item.nx !== want.nx) report_mismatch("nx", o_item.nx, want.nx);
                if (o_item.ny !== want.ny) report_mismatch("ny", o_item.ny, want.ny);
                if (o_item.nz !== want.nz) report_mismatch("nz", o_item.nz, want.nz);
                if (o_item.degenerate !== want.degenerate)
                    report_mismatch("degenerate", o_item.degenerate, want.degenerate);
                if (want.degenerate) degenerate_seen++;
            end
            received++;
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 5000) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_in make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                     int x2, int y2, int z2);
        t_in t;
        t.ax = 16'(x0); t.ay = 16'(y0); t.az = 16'(z0);
        t.bx = 16'(x1); t.by = 16'(y1); t.bz = 16'(z1);
        t.cx = 16'(x2); t.cy = 16'(y2); t.cz = 16'(z2);
        return t;
    endfunction

    task automatic add_tris(int count);
        int g;
        for (int i = 0; i < count; i++) begin
            pending_tris.push_back(random_tri());
            g = gap_len();
            repeat (g) @(posedge i_clk);
            if ($urandom_range(0, 7) == 0) @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // Extremes, axis-aligned faces, coincident and collinear corners.
        pending_tris.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
        pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
        pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                        -32768, 32767, -32768));
        pending_tris.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                        32767, -32768, -32768));
        pending_tris.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                        -32768, -32768, 32767));
        pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                        -32768, -32768, -32768));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 2, 3, 3, 1, 2));
        pending_tris.push_back(make_tri(-1, -1, -1, 0, 0, 0, 1, -1, 0));
        pending_tris.push_back(make_tri(100, -200, 300, -400, 500, -600, 700, 800, -900));
        pending_tris.push_back(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
        add_tris(340);
        wait (pending_tris.size() == 0 && expected_normals.size() == 0 && !i_valid);
        hold_sender = 1'b1;
        repeat (60) @(posedge i_clk);
        hold_sender = 1'b0;
        add_tris(340);
        wait (pending_tris.size() == 0 && expected_normals.size() == 0 && !i_valid);
        repeat (80) @(posedge i_clk);
        $display("covered %0d triangles, %0d results, %0d degenerate", accepted, received,
                 degenerate_seen);
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/tun_pkg.sv
rtl/core/tun_front.sv
rtl/core/tun_sqrt_cell.sv
rtl/core/tun_div_cell.sv
rtl/core/triangle_unit_normal.sv
verif/testbench.sv
